FILE: rtl/kbs_pkg.sv
// Package for the keyed blob store: sizes, operation and result codes,
// controller states and the command/status structs. No dependencies.
package kbs_pkg;

  localparam int TBL_SLOTS   = 16;
  localparam int BLOB_BYTES  = 32;
  localparam int STG_SLOTS   = 6;
  localparam int MAX_RESULTS = 32;

  localparam int KEY_W     = 16;
  localparam int REQ_W     = 12;
  localparam int LEN_W     = $clog2(BLOB_BYTES + 1);
  localparam int TBL_AW    = (TBL_SLOTS > 1) ? $clog2(TBL_SLOTS) : 1;
  localparam int STG_AW    = (STG_SLOTS > 1) ? $clog2(STG_SLOTS) : 1;
  localparam int CNT_W     = $clog2(STG_SLOTS + 1);
  localparam int TMEM_D    = TBL_SLOTS * BLOB_BYTES;
  localparam int SMEM_D    = STG_SLOTS * BLOB_BYTES;
  localparam int TMEM_AW   = (TMEM_D > 1) ? $clog2(TMEM_D) : 1;
  localparam int SMEM_AW   = (SMEM_D > 1) ? $clog2(SMEM_D) : 1;
  localparam logic [KEY_W-1:0] KEY_LIMIT_RST = KEY_W'(512);

  typedef enum logic [1:0] {
    OP_LOOKUP  = 2'd0,
    OP_STASH   = 2'd1,
    OP_PROMOTE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RK_MISS    = 2'd0,
    RK_DATA    = 2'd1,
    RK_PROMOTE = 2'd2,
    RK_CLEAR   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PR_SCAN,
    ST_PR_COPY,
    ST_PR_DRAIN,
    ST_LK_READ,
    ST_LK_EMIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic  stash;
    logic  end_stage;
    logic  pr_start;
    logic  pr_sel;
    logic  pr_skip;
    logic  copy_step;
    logic  lk_start;
    logic  lk_read;
    logic  lk_adv;
    logic  out_load;
    kind_e out_kind;
    logic  out_last;
  } cmd_t;

  typedef struct packed {
    logic pr_more;
    logic pr_len_zero;
    logic copy_done;
    logic lk_hit;
    logic lk_last;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/keyed_blob_store_fifo_evict_core.sv
// Keyed blob store with staging and FIFO eviction, top level.
// Joins kbs_ctrl and kbs_dp; depends on kbs_pkg.
//
// Usage:
//  Input words (operation, key, mode, byte, last, length) are taken on
//  in_valid_i && !in_stall_o. Result words leave on out_valid_o and are
//  taken when out_stall_i is low; an output register holds a stalled
//  word while the next input word may already be accepted.
//  The key limit register is written on cfg_valid_i (cfg_ready_o is
//  always high); write it only while the block is idle.
//  A lookup hit returns each byte by a table memory read and then an
//  output load; a promote visits every staging slot and copies the bytes
//  of each nonempty slot through the staging memory read port.
//  While the output is stalled the controller holds its next word and
//  the input stays stalled. Reset empties the table and staging, zeroes
//  the eviction cursor and sets the key limit to 512; no clearing pass.
module keyed_blob_store_fifo_evict_core import kbs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [KEY_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       operation_i,
  input  logic [KEY_W-1:0] entry_key_i,
  input  logic             compat_mode_i,
  input  logic [7:0]       data_byte_i,
  input  logic             stash_last_i,
  input  logic [REQ_W-1:0] request_length_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       result_kind_o,
  output logic [7:0]       out_byte_o,
  output logic             last_of_run_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  kbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  kbs_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .entry_key_i      (entry_key_i),
    .compat_mode_i    (compat_mode_i),
    .data_byte_i      (data_byte_i),
    .stash_last_i     (stash_last_i),
    .request_length_i (request_length_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_o    (result_kind_o),
    .out_byte_o       (out_byte_o),
    .last_of_run_o    (last_of_run_o)
  );

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free) else $error("result word loaded over a held word");

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.stash, cmd.pr_sel, cmd.copy_step, cmd.lk_start, cmd.lk_read,
              cmd.out_load})) else $error("conflicting datapath commands");

  a_copy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.copy_step |-> !sts.copy_done) else $error("copy past blob length");

  a_stash_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.stash |-> (in_valid_i && !in_stall_o)) else $error("stash without accept");

endmodule

FILE: rtl/kbs_ctrl.sv
// Controller FSM for the keyed blob store: sequences stash, promote,
// lookup and result words. Depends on kbs_pkg.
module kbs_ctrl import kbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= RK_MISS;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    cmd_o      = '0;
    cmd_o.out_kind = RK_MISS;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op_e'(operation_i))
            OP_LOOKUP: begin
              cmd_o.lk_start = 1'b1;
              if (sts_i.lk_hit) begin
                state_d = ST_LK_READ;
              end else begin
                kind_d  = RK_MISS;
                state_d = ST_EMIT;
              end
            end
            OP_STASH: cmd_o.stash = 1'b1;
            OP_PROMOTE: begin
              cmd_o.pr_start = 1'b1;
              state_d = ST_PR_SCAN;
            end
            default: begin
              cmd_o.end_stage = 1'b1;
              kind_d  = RK_CLEAR;
              state_d = ST_EMIT;
            end
          endcase
        end
      end
      ST_PR_SCAN: begin
        if (!sts_i.pr_more) begin
          cmd_o.end_stage = 1'b1;
          kind_d  = RK_PROMOTE;
          state_d = ST_EMIT;
        end else if (sts_i.pr_len_zero) begin
          cmd_o.pr_skip = 1'b1;
        end else begin
          cmd_o.pr_sel = 1'b1;
          state_d = ST_PR_COPY;
        end
      end
      ST_PR_COPY: begin
        if (sts_i.copy_done) begin
          state_d = ST_PR_DRAIN;
        end else begin
          cmd_o.copy_step = 1'b1;
        end
      end
      ST_PR_DRAIN: begin
        cmd_o.pr_skip = 1'b1;
        state_d = ST_PR_SCAN;
      end
      ST_LK_READ: begin
        cmd_o.lk_read = 1'b1;
        state_d = ST_LK_EMIT;
      end
      ST_LK_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = RK_DATA;
          cmd_o.out_last = sts_i.lk_last;
          if (sts_i.lk_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.lk_adv = 1'b1;
            state_d = ST_LK_READ;
          end
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = kind_q;
          cmd_o.out_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/kbs_dp.sv
// Datapath of the keyed blob store: table and staging stores, byte
// memories, search logic and the output word register. Depends on kbs_pkg.
module kbs_dp import kbs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [KEY_W-1:0] cfg_data_i,
  input  logic [KEY_W-1:0] entry_key_i,
  input  logic             compat_mode_i,
  input  logic [7:0]       data_byte_i,
  input  logic             stash_last_i,
  input  logic [REQ_W-1:0] request_length_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       result_kind_o,
  output logic [7:0]       out_byte_o,
  output logic             last_of_run_o
);

  logic [KEY_W-1:0]  key_limit_q;
  logic [LEN_W-1:0]  tbl_len_q  [TBL_SLOTS];
  logic [KEY_W-1:0]  tbl_key_q  [TBL_SLOTS];
  logic              tbl_mode_q [TBL_SLOTS];
  logic [TBL_AW-1:0] cursor_q;
  logic [LEN_W-1:0]  stg_len_q  [STG_SLOTS];
  logic [KEY_W-1:0]  stg_key_q  [STG_SLOTS];
  logic              stg_mode_q [STG_SLOTS];
  logic [CNT_W-1:0]  stg_cnt_q;
  logic              st_open_q, st_drop_q;
  logic [STG_AW-1:0] st_slot_q;
  logic [CNT_W-1:0]  pr_idx_q;
  logic [TBL_AW-1:0] pr_dst_q;
  logic [LEN_W-1:0]  pr_n_q;
  logic [LEN_W-1:0]  k_q;
  logic              wr_en_q;
  logic [LEN_W-1:0]  wr_k_q;
  logic [TBL_AW-1:0] lk_slot_q;
  logic [LEN_W-1:0]  lk_n_q;
  logic [7:0]        tbl_mem [TMEM_D];
  logic [7:0]        stg_mem [SMEM_D];
  logic [7:0]        tbl_rdata_q, stg_rdata_q;
  logic              out_valid_q, out_last_q;
  logic [1:0]        out_kind_q;
  logic [7:0]        out_byte_q;

  // stash slot search
  logic              s_found, s_drop, s_new;
  logic [STG_AW-1:0] s_slot, s_hit;
  logic [LEN_W-1:0]  s_len;
  always_comb begin
    s_found = 1'b0;
    s_hit   = '0;
    for (int i = STG_SLOTS - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < stg_cnt_q) && stg_key_q[i] == entry_key_i &&
          stg_mode_q[i] == compat_mode_i) begin
        s_found = 1'b1;
        s_hit   = STG_AW'(i);
      end
    end
    s_new  = 1'b0;
    s_drop = st_drop_q;
    s_slot = st_slot_q;
    if (!st_open_q) begin
      s_drop = 1'b0;
      if (entry_key_i >= key_limit_q) begin
        s_drop = 1'b1;
      end else if (s_found) begin
        s_slot = s_hit;
      end else if (stg_cnt_q >= CNT_W'(STG_SLOTS)) begin
        s_drop = 1'b1;
      end else begin
        s_new  = 1'b1;
        s_slot = stg_cnt_q[STG_AW-1:0];
      end
    end
    s_len = st_open_q ? stg_len_q[s_slot] : '0;
  end

  // promote destination search
  logic [STG_AW-1:0] p_i;
  logic              p_match, p_empty;
  logic [TBL_AW-1:0] p_mslot, p_eslot, p_dst;
  always_comb begin
    p_i     = pr_idx_q[STG_AW-1:0];
    p_match = 1'b0;
    p_empty = 1'b0;
    p_mslot = '0;
    p_eslot = '0;
    for (int j = TBL_SLOTS - 1; j >= 0; j--) begin
      if (tbl_len_q[j] != '0 && tbl_key_q[j] == stg_key_q[p_i] &&
          tbl_mode_q[j] == stg_mode_q[p_i]) begin
        p_match = 1'b1;
        p_mslot = TBL_AW'(j);
      end
      if (tbl_len_q[j] == '0) begin
        p_empty = 1'b1;
        p_eslot = TBL_AW'(j);
      end
    end
    p_dst = p_match ? p_mslot : (p_empty ? p_eslot : cursor_q);
  end

  // lookup search
  logic              l_match;
  logic [TBL_AW-1:0] l_slot;
  logic [REQ_W-1:0]  l_len_w;
  logic [LEN_W-1:0]  l_n;
  always_comb begin
    l_match = 1'b0;
    l_slot  = '0;
    for (int j = TBL_SLOTS - 1; j >= 0; j--) begin
      if (tbl_len_q[j] != '0 && tbl_key_q[j] == entry_key_i &&
          tbl_mode_q[j] == compat_mode_i) begin
        l_match = 1'b1;
        l_slot  = TBL_AW'(j);
      end
    end
    l_len_w = REQ_W'(tbl_len_q[l_slot]);
    l_n = (l_len_w < request_length_i) ? tbl_len_q[l_slot]
                                       : request_length_i[LEN_W-1:0];
    if (l_n > LEN_W'(MAX_RESULTS)) l_n = LEN_W'(MAX_RESULTS);
  end

  assign sts_o.pr_more     = pr_idx_q < stg_cnt_q;
  assign sts_o.pr_len_zero = stg_len_q[p_i] == '0;
  assign sts_o.copy_done   = k_q == pr_n_q;
  assign sts_o.lk_hit      = l_match && (entry_key_i < key_limit_q) &&
                             (request_length_i != '0);
  assign sts_o.lk_last     = (k_q + LEN_W'(1)) == lk_n_q;
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_limit_q <= KEY_LIMIT_RST;
      for (int j = 0; j < TBL_SLOTS; j++) tbl_len_q[j] <= '0;
      cursor_q    <= '0;
      stg_cnt_q   <= '0;
      st_open_q   <= 1'b0;
      st_drop_q   <= 1'b0;
      st_slot_q   <= '0;
      pr_idx_q    <= '0;
      k_q         <= '0;
      wr_en_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) key_limit_q <= cfg_data_i;
      wr_en_q <= cmd_i.copy_step;
      if (cmd_i.stash) begin
        if (s_new) stg_cnt_q <= stg_cnt_q + CNT_W'(1);
        if (!s_drop && s_len < LEN_W'(BLOB_BYTES)) begin
          stg_len_q[s_slot] <= s_len + LEN_W'(1);
        end
        if (!st_open_q && !s_drop) begin
          stg_key_q[s_slot]  <= entry_key_i;
          stg_mode_q[s_slot] <= compat_mode_i;
        end
        st_open_q <= !stash_last_i;
        st_drop_q <= stash_last_i ? 1'b0 : s_drop;
        st_slot_q <= s_slot;
      end
      if (cmd_i.end_stage) begin
        stg_cnt_q <= '0;
        if (st_open_q) st_drop_q <= 1'b1;
      end
      if (cmd_i.pr_start) pr_idx_q <= '0;
      if (cmd_i.pr_skip) pr_idx_q <= pr_idx_q + CNT_W'(1);
      if (cmd_i.pr_sel) begin
        tbl_len_q[p_dst]  <= stg_len_q[p_i];
        tbl_key_q[p_dst]  <= stg_key_q[p_i];
        tbl_mode_q[p_dst] <= stg_mode_q[p_i];
        pr_dst_q <= p_dst;
        pr_n_q   <= stg_len_q[p_i];
        k_q      <= '0;
        if (!p_match && !p_empty) begin
          cursor_q <= (cursor_q == TBL_AW'(TBL_SLOTS - 1)) ? '0
                                                           : cursor_q + TBL_AW'(1);
        end
      end
      if (cmd_i.copy_step) begin
        wr_k_q <= k_q;
        k_q    <= k_q + LEN_W'(1);
      end
      if (cmd_i.lk_start) begin
        lk_slot_q <= l_slot;
        lk_n_q    <= l_n;
        k_q       <= '0;
      end
      if (cmd_i.lk_adv) k_q <= k_q + LEN_W'(1);
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        out_kind_q  <= cmd_i.out_kind;
        out_byte_q  <= (cmd_i.out_kind == RK_DATA) ? tbl_rdata_q : 8'h00;
        out_last_q  <= cmd_i.out_last;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // byte memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.stash && !s_drop && s_len < LEN_W'(BLOB_BYTES)) begin
      stg_mem[SMEM_AW'(s_slot * BLOB_BYTES + s_len)] <= data_byte_i;
    end
    if (cmd_i.copy_step) begin
      stg_rdata_q <= stg_mem[SMEM_AW'(p_i * BLOB_BYTES + k_q)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_q) begin
      tbl_mem[TMEM_AW'(pr_dst_q * BLOB_BYTES + wr_k_q)] <= stg_rdata_q;
    end
    if (cmd_i.lk_read) begin
      tbl_rdata_q <= tbl_mem[TMEM_AW'(lk_slot_q * BLOB_BYTES + k_q)];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

endmodule

FILE: tb/tb.sv
// Testbench for keyed_blob_store_fifo_evict_core: stash, promote, lookup and clear
// checked word by word against an in-bench model of the keyed blob table.
// Depends on kbs_pkg and the core RTL.
`timescale 1ns / 100ps

module tb;
  import kbs_pkg::*;

  typedef struct packed {
    op_e              op;
    logic [KEY_W-1:0] key;
    logic             mode;
    logic [7:0]       data;
    logic             last;
    logic [REQ_W-1:0] req;
  } cmd_word_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } res_word_t;

  typedef struct packed {
    cmd_word_t w;
    logic      chk;
    res_word_t r;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [KEY_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] operation_i = '0;
  logic [KEY_W-1:0] entry_key_i = '0;
  logic compat_mode_i = 1'b0;
  logic [7:0] data_byte_i = '0;
  logic stash_last_i = 1'b0;
  logic [REQ_W-1:0] request_length_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic [1:0] result_kind_o;
  logic [7:0] out_byte_o;
  logic last_of_run_o;

  keyed_blob_store_fifo_evict_core i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_stall_o, .operation_i, .entry_key_i, .compat_mode_i,
    .data_byte_i, .stash_last_i, .request_length_i,
    .out_valid_o, .out_stall_i, .result_kind_o, .out_byte_o, .last_of_run_o
  );

  always #6 clk_i = ~clk_i;

  // model state
  logic [KEY_W-1:0] lim;
  logic [7:0]       tbl_bytes [TBL_SLOTS][BLOB_BYTES];
  int               tbl_len [TBL_SLOTS];
  logic [KEY_W-1:0] tbl_key [TBL_SLOTS];
  logic             tbl_mode [TBL_SLOTS];
  int               cursor;
  logic [7:0]       stg_bytes [STG_SLOTS][BLOB_BYTES];
  int               stg_len [STG_SLOTS];
  logic [KEY_W-1:0] stg_key [STG_SLOTS];
  logic             stg_mode [STG_SLOTS];
  int               stg_cnt;
  bit               blob_open, blob_drop;
  int               blob_slot;

  res_word_t expected_q [$];
  int        errors, results_seen, words_sent, cycles;
  int        snd_idle_pct, rcv_idle_pct;
  bit        rcv_hold;

  task automatic report(input string what);
    errors++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  function automatic void model_reset();
    lim = KEY_LIMIT_RST;
    cursor = 0; stg_cnt = 0; blob_open = 0; blob_drop = 0; blob_slot = 0;
    for (int i = 0; i < TBL_SLOTS; i++) tbl_len[i] = 0;
  endfunction

  function automatic void drop_staging();
    stg_cnt = 0;
    if (blob_open) blob_drop = 1;
  endfunction

  function automatic void predict_word(input cmd_word_t w);
    int n, dst;
    res_word_t r;
    case (w.op)
      OP_STASH: begin
        if (!blob_open) begin
          blob_open = 1; blob_drop = 0;
          if (w.key >= lim) blob_drop = 1;
          else begin
            dst = -1;
            for (int i = 0; i < stg_cnt; i++)
              if (dst < 0 && stg_key[i] == w.key && stg_mode[i] == w.mode) dst = i;
            if (dst < 0) begin
              if (stg_cnt >= STG_SLOTS) blob_drop = 1;
              else dst = stg_cnt++;
            end
            if (!blob_drop) begin
              blob_slot = dst; stg_key[dst] = w.key; stg_mode[dst] = w.mode;
              stg_len[dst] = 0;
            end
          end
        end
        if (!blob_drop && stg_len[blob_slot] < BLOB_BYTES) begin
          stg_bytes[blob_slot][stg_len[blob_slot]] = w.data;
          stg_len[blob_slot]++;
        end
        if (w.last) begin
          blob_open = 0; blob_drop = 0;
        end
      end
      OP_PROMOTE: begin
        for (int i = 0; i < stg_cnt; i++) begin
          if (stg_len[i] != 0) begin
            dst = -1;
            for (int j = 0; j < TBL_SLOTS; j++)
              if (dst < 0 && tbl_len[j] != 0 && tbl_key[j] == stg_key[i]
                  && tbl_mode[j] == stg_mode[i]) dst = j;
            for (int j = 0; j < TBL_SLOTS; j++)
              if (dst < 0 && tbl_len[j] == 0) dst = j;
            if (dst < 0) begin
              dst = cursor; cursor = (cursor + 1) % TBL_SLOTS;
            end
            for (int k = 0; k < stg_len[i]; k++) tbl_bytes[dst][k] = stg_bytes[i][k];
            tbl_len[dst] = stg_len[i]; tbl_key[dst] = stg_key[i];
            tbl_mode[dst] = stg_mode[i];
          end
        end
        drop_staging();
        r.kind = RK_PROMOTE; r.data = '0; r.last = 1'b1; expected_q.push_back(r);
      end
      OP_CLEAR: begin
        drop_staging();
        r.kind = RK_CLEAR; r.data = '0; r.last = 1'b1; expected_q.push_back(r);
      end
      default: begin
        dst = -1;
        if (w.key < lim && w.req != 0)
          for (int j = 0; j < TBL_SLOTS; j++)
            if (dst < 0 && tbl_len[j] != 0 && tbl_key[j] == w.key
                && tbl_mode[j] == w.mode) dst = j;
        if (dst < 0) begin
          r.kind = RK_MISS; r.data = '0; r.last = 1'b1; expected_q.push_back(r);
        end else begin
          n = tbl_len[dst];
          if (n > w.req) n = w.req;
          for (int k = 0; k < n; k++) begin
            r.kind = RK_DATA; r.data = tbl_bytes[dst][k]; r.last = (k == n - 1);
            expected_q.push_back(r);
          end
        end
      end
    endcase
  endfunction

  // valid stays high after a word so the next word can follow back to back
  task automatic send_word(input cmd_word_t w);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= w.op; entry_key_i <= w.key; compat_mode_i <= w.mode;
    data_byte_i <= w.data; stash_last_i <= w.last; request_length_i <= w.req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_word(w);
    words_sent++;
  endtask

  task automatic quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_and_settle();
    quiet();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [KEY_W-1:0] v);
    cfg_valid_i <= 1'b1; cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    lim = v;
  endtask

  function automatic cmd_word_t mk(input op_e op, input int key, input int mode,
                                   input int data, input int last, input int req);
    cmd_word_t w;
    w.op = op; w.key = KEY_W'(key); w.mode = 1'(mode); w.data = 8'(data);
    w.last = 1'(last); w.req = REQ_W'(req);
    return w;
  endfunction

  // a well-formed blob with the given key, mode and length and random data bytes
  task automatic send_blob(input int key, input int mode, input int len);
    for (int k = 0; k < len; k++)
      send_word(mk(OP_STASH, (k == 0) ? key : $urandom_range(65535),
                   (k == 0) ? mode : $urandom_range(1), $urandom_range(255),
                   k == len - 1, $urandom_range(4095)));
  endtask

  task automatic random_phase(input int count, input int key_span);
    int c, pick, len;
    c = 0;
    while (c < count) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 6);
        send_blob($urandom_range(key_span), $urandom_range(1), len);
        c += len - 1;
      end else if (pick < 65)
        send_word(mk(OP_LOOKUP, $urandom_range(key_span), $urandom_range(1), 0, 0,
                     ($urandom_range(7) == 0) ? $urandom_range(4095) : $urandom_range(40)));
      else if (pick < 80) send_word(mk(OP_PROMOTE, $urandom_range(65535),
                                       $urandom_range(1), $urandom_range(255),
                                       $urandom_range(1), $urandom_range(4095)));
      else if (pick < 85) send_word(mk(OP_CLEAR, $urandom_range(65535), 0, 0, 0, 0));
      else send_word(mk(op_e'($urandom_range(3)), $urandom_range(65535),
                        $urandom_range(1), $urandom_range(255), $urandom_range(1),
                        $urandom_range(4095)));
      c++;
    end
  endtask

  // receiver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_q.size() == 0) report("result word with none expected");
        else begin
          res_word_t e;
          e = expected_q.pop_front();
          if (result_kind_o !== e.kind)
            report($sformatf("kind %0d, expected %0d", result_kind_o, e.kind));
          if (out_byte_o !== e.data)
            report($sformatf("byte %02h, expected %02h", out_byte_o, e.data));
          if (last_of_run_o !== e.last)
            report($sformatf("last %0b, expected %0b", last_of_run_o, e.last));
        end
      end
      out_stall_i <= rcv_hold || ($urandom_range(99) < rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  dir_row_t dir_tbl [$];

  initial begin
    model_reset();
    snd_idle_pct = 0; rcv_idle_pct = 0; rcv_hold = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed; chk rows carry a hand-typed result
    dir_tbl = '{
      '{mk(OP_LOOKUP, 0, 0, 0, 0, 4095), 1, '{RK_MISS, 8'h00, 1'b1}},
      '{mk(OP_PROMOTE, 0, 0, 0, 0, 0), 1, '{RK_PROMOTE, 8'h00, 1'b1}},
      '{mk(OP_CLEAR, 0, 0, 0, 0, 0), 1, '{RK_CLEAR, 8'h00, 1'b1}},
      '{mk(OP_STASH, 511, 1, 8'hff, 0, 0), 0, '0},
      '{mk(OP_STASH, 7, 0, 8'h00, 1, 0), 0, '0},
      '{mk(OP_STASH, 512, 0, 8'haa, 1, 0), 0, '0},
      '{mk(OP_STASH, 65535, 1, 8'h55, 1, 0), 0, '0},
      '{mk(OP_STASH, 0, 0, 8'h12, 0, 0), 0, '0},
      '{mk(OP_PROMOTE, 0, 0, 0, 0, 0), 1, '{RK_PROMOTE, 8'h00, 1'b1}},
      '{mk(OP_STASH, 0, 0, 8'h34, 1, 0), 0, '0},
      '{mk(OP_LOOKUP, 511, 1, 0, 0, 4095), 0, '0},
      '{mk(OP_LOOKUP, 511, 1, 0, 0, 1), 1, '{RK_DATA, 8'hff, 1'b1}},
      '{mk(OP_LOOKUP, 511, 1, 0, 0, 0), 1, '{RK_MISS, 8'h00, 1'b1}},
      '{mk(OP_LOOKUP, 0, 0, 0, 0, 5), 1, '{RK_DATA, 8'h12, 1'b1}},
      '{mk(OP_LOOKUP, 512, 0, 0, 0, 5), 1, '{RK_MISS, 8'h00, 1'b1}},
      '{mk(OP_STASH, 3, 1, 8'h01, 0, 0), 0, '0},
      '{mk(OP_CLEAR, 0, 0, 0, 0, 0), 1, '{RK_CLEAR, 8'h00, 1'b1}},
      '{mk(OP_STASH, 3, 1, 8'h02, 1, 0), 0, '0},
      '{mk(OP_LOOKUP, 3, 1, 0, 0, 9), 1, '{RK_MISS, 8'h00, 1'b1}}
    };
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].chk) begin
        quiet();
        while (expected_q.size() != 0) @(posedge clk_i);
        send_word(dir_tbl[i].w);
        if (expected_q.size() != 1 || expected_q[0] !== dir_tbl[i].r)
          report($sformatf("directed row %0d: model disagrees with table", i));
      end else send_word(dir_tbl[i].w);
    end
    // full staging, long blob, eviction over a full table
    for (int b = 0; b < 8; b++) send_blob(20 + b, b[0], (b == 0) ? 36 : 3);
    send_word(mk(OP_PROMOTE, 0, 0, 0, 0, 0));
    for (int b = 0; b < 14; b++) begin
      send_blob(40 + b, 0, 2);
      if (b % 5 == 4) send_word(mk(OP_PROMOTE, 0, 0, 0, 0, 0));
    end
    send_word(mk(OP_PROMOTE, 0, 0, 0, 0, 0));
    send_word(mk(OP_LOOKUP, 20, 0, 0, 0, 4095));
    drain_and_settle();

    // backpressure: receiver held while the sender keeps going
    fork
      begin
        rcv_hold = 1;
        repeat (400) @(posedge clk_i);
        rcv_hold = 0;
      end
      for (int k = 0; k < 12; k++) send_word(mk(OP_LOOKUP, 21, 1, 0, 0, 3));
    join
    drain_and_settle();

    snd_idle_pct = 26; rcv_idle_pct = 65;
    random_phase(100, 24);
    drain_and_settle();
    write_limit(16'd0);
    random_phase(15, 24);
    drain_and_settle();
    write_limit(16'hffff);
    snd_idle_pct = 65; rcv_idle_pct = 26;
    random_phase(100, 24);
    send_blob(65534, 1, 4);
    send_word(mk(OP_PROMOTE, 0, 0, 0, 0, 0));
    send_word(mk(OP_LOOKUP, 65534, 1, 0, 0, 4095));
    drain_and_settle();
    write_limit(16'd10);
    snd_idle_pct = 0; rcv_idle_pct = 0;
    random_phase(85, 16);
    drain_and_settle();

    $display("Sent %0d input words, checked %0d result words, key limits 512/0/65535/10.",
             words_sent, results_seen);
    if (errors == 0 && expected_q.size() == 0)
      $display("Testbench completed without errors");
    else begin
      $display("%0d mismatches, %0d words still expected", errors, expected_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
